// ===== sv/lz77td_pkg.sv =====
// ----------------------------------------------------------------------------
// lz77td_pkg
// Shared types and constants of the LZ77 token decompressor: window port
// structs, parse phases, sequencer states, error codes and token field codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lz77td_pkg;

  // History window geometry
  localparam int WIN_AW = 16;
  localparam int BYTE_W = 8;

  // Token counters (literal count and match length, up to 272)
  localparam int CNT_W = 9;

  // Result channel widths
  localparam int OUT_BYTES_W   = 64;
  localparam int OUT_COUNT_W   = 4;
  localparam int OUT_LANES_DEF = 8;

  // Token field codes
  localparam logic [1:0] LIT_ESC_CODE = 2'd0;
  localparam logic [1:0] OFF_ESC_CODE = 2'd3;
  localparam logic [3:0] LEN_ESC_CODE = 4'hF;
  localparam logic [CNT_W-1:0] LIT_ESC_BIAS = 9'd2;
  localparam logic [CNT_W-1:0] LEN_ESC_BIAS = 9'd15;
  localparam logic [CNT_W-1:0] MATCH_BIAS   = 9'd2;
  localparam logic [WIN_AW-1:0] PROD_MAX    = 16'hFFFF;

  // Error codes on the result channel
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TRUNC = 2'd1,
    ERR_RANGE = 2'd2
  } err_t;

  // Parse phase of the token decoder
  typedef enum logic [6:0] {
    PH_OPCODE   = 7'b0000001,
    PH_LIT_ESC  = 7'b0000010,
    PH_LEN_ESC  = 7'b0000100,
    PH_LITERALS = 7'b0001000,
    PH_OFF_LOW  = 7'b0010000,
    PH_OFF_HIGH = 7'b0100000,
    PH_DRAIN    = 7'b1000000
  } phase_t;

  // Control sequencer
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_COPY = 2'b10
  } ctl_state_t;

  // Window write port
  typedef struct packed {
    logic              en;
    logic [WIN_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } win_wr_t;

  // Window read port
  typedef struct packed {
    logic              en;
    logic [WIN_AW-1:0] addr;
  } win_rd_t;

endpackage

`default_nettype wire

// ===== sv/lz77td_window.sv =====
// ----------------------------------------------------------------------------
// lz77td_window
// 64 KiB history window: one write and one read per cycle, read data
// registered, with a bypass when the read hits the byte written that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lz77td_window (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lz77td_pkg::win_wr_t         wr,
  input  wire lz77td_pkg::win_rd_t         rd,
  output logic [lz77td_pkg::BYTE_W-1:0]    rd_data
);

  localparam int DEPTH = 1 << lz77td_pkg::WIN_AW;

  logic [lz77td_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [lz77td_pkg::BYTE_W-1:0] q_r;
  logic [lz77td_pkg::BYTE_W-1:0] byp_r;
  logic                          fwd_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      q_r   <= mem[rd.addr];
      byp_r <= wr.data;
    end
  end

  // Flag a read that collides with the write of the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd.en) begin
      fwd_r <= wr.en && (wr.addr == rd.addr);
    end
  end

  // Take the fresh byte over the stale array data on a collision
  assign rd_data = fwd_r ? byp_r : q_r;

endmodule

`default_nettype wire

// ===== sv/lz77_token_decompressor_top.sv =====
// ----------------------------------------------------------------------------
// lz77_token_decompressor_top
// Streaming LZ77 token decoder: one compressed byte per input transaction,
// decoded bytes packed up to OUT_LANES per result transaction, with a
// 64 KiB history window for back-references.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------
//   in_     | input     | in_valid / in_ready    | in_byte, in_stream_end
//   out_    | output    | out_valid / out_ready  | out_bytes, out_count,
//           |           |                        | out_error_code, out_run_last,
//           |           |                        | out_stream_done
//
// A byte is held in the input register with in_ready low until it is decoded,
// so a new byte is not taken while one waits; most bytes yield one result.
// A match of N = L+2 bytes then runs a copy with one window read per cycle
// unless stalled. The next byte may be taken meanwhile.
// A result that is not taken stalls decode, and stalls the copy at word ends.
// Reset is synchronous and clears the decoder state; the window is not cleared.
//
`default_nettype none

module lz77_token_decompressor_top #(
  parameter int OUT_LANES = lz77td_pkg::OUT_LANES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [lz77td_pkg::BYTE_W-1:0]       in_byte,
  input  wire logic                                in_stream_end,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [lz77td_pkg::OUT_BYTES_W-1:0]       out_bytes,
  output logic [lz77td_pkg::OUT_COUNT_W-1:0]       out_count,
  output logic [1:0]                               out_error_code,
  output logic                                     out_run_last,
  output logic                                     out_stream_done
);

  localparam int LANE_W = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;
  localparam int AW     = lz77td_pkg::WIN_AW;
  localparam int CW     = lz77td_pkg::CNT_W;
  localparam int BW     = lz77td_pkg::BYTE_W;
  localparam int OW     = lz77td_pkg::OUT_BYTES_W;
  localparam int NW     = lz77td_pkg::OUT_COUNT_W;
  localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(OUT_LANES - 1);

  // Pick the phase that follows the count bytes of a token
  function automatic lz77td_pkg::phase_t after_counts(input logic [CW-1:0] ll,
                                                      input logic [CW-1:0] ml);
    lz77td_pkg::phase_t p;
    if (ll != '0) begin
      p = lz77td_pkg::PH_LITERALS;
    end else if (ml != '0) begin
      p = lz77td_pkg::PH_OFF_LOW;
    end else begin
      p = lz77td_pkg::PH_OPCODE;
    end
    return p;
  endfunction

  // Input holding register
  logic          in_full_r, in_full_nxt;
  logic [BW-1:0] in_byte_r, in_byte_nxt;
  logic          in_end_r, in_end_nxt;

  // Sequencer and parse state
  lz77td_pkg::ctl_state_t state_r, state_nxt;
  lz77td_pkg::phase_t     phase_r, phase_nxt;
  logic [CW-1:0]          ll_r, ll_nxt;
  logic [CW-1:0]          ml_r, ml_nxt;
  logic [1:0]             ohc_r, ohc_nxt;
  logic [BW-1:0]          ol_r, ol_nxt;
  logic [AW-1:0]          wp_r, wp_nxt;
  logic [AW-1:0]          prod_r, prod_nxt;
  logic                   err_lat_r, err_lat_nxt;

  // Copy engine
  logic                   copy_end_r, copy_end_nxt;
  logic [AW-1:0]          src_r, src_nxt;
  logic [CW-1:0]          left_r, left_nxt;
  logic                   pend_r, pend_nxt;
  logic [OW-1:0]          acc_r, acc_nxt;
  logic [LANE_W-1:0]      lane_r, lane_nxt;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  logic [OW-1:0]          out_bytes_r, out_bytes_nxt;
  logic [NW-1:0]          out_count_r, out_count_nxt;
  lz77td_pkg::err_t       out_err_r, out_err_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_done_r, out_done_nxt;

  // Window ports
  lz77td_pkg::win_wr_t    win_wr;
  lz77td_pkg::win_rd_t    win_rd;
  logic [BW-1:0]          win_q;

  logic                   out_free;
  logic                   word_done;

  lz77td_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (win_wr),
    .rd      (win_rd),
    .rd_data (win_q)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = !in_full_r;
  assign word_done = pend_r && ((lane_r == LAST_LANE) || (left_r == '0));

  // Decode, copy and result packing
  always_comb begin
    logic [15:0]      offset;
    logic             do_check;
    logic             load_out;
    logic             clear;
    lz77td_pkg::err_t err;
    logic [OW-1:0]    acc_w;
    logic [CW-1:0]    ll_v;
    logic [CW-1:0]    ml_v;

    offset   = '0;
    do_check = 1'b0;
    load_out = 1'b0;
    clear    = 1'b0;
    err      = lz77td_pkg::ERR_NONE;
    acc_w    = acc_r;
    ll_v     = '0;
    ml_v     = '0;

    in_full_nxt   = in_full_r;
    in_byte_nxt   = in_byte_r;
    in_end_nxt    = in_end_r;
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    ll_nxt        = ll_r;
    ml_nxt        = ml_r;
    ohc_nxt       = ohc_r;
    ol_nxt        = ol_r;
    wp_nxt        = wp_r;
    prod_nxt      = prod_r;
    err_lat_nxt   = err_lat_r;
    copy_end_nxt  = copy_end_r;
    src_nxt       = src_r;
    left_nxt      = left_r;
    pend_nxt      = pend_r;
    acc_nxt       = acc_r;
    lane_nxt      = lane_r;
    out_bytes_nxt = out_bytes_r;
    out_count_nxt = out_count_r;
    out_err_nxt   = out_err_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    win_wr        = '0;
    win_rd        = '0;

    // Retire the result being taken
    out_valid_nxt = out_valid_r && !out_ready;

    // Capture an incoming transaction
    if (in_valid && !in_full_r) begin
      in_full_nxt = 1'b1;
      in_byte_nxt = in_byte;
      in_end_nxt  = in_stream_end;
    end

    case (state_r)
      lz77td_pkg::S_IDLE: begin
        if (in_full_r && out_free) begin
          in_full_nxt   = 1'b0;
          load_out      = 1'b1;
          out_bytes_nxt = '0;
          out_count_nxt = '0;

          case (phase_r)
            lz77td_pkg::PH_OPCODE: begin
              ohc_nxt = in_byte_r[3:2];
              ml_v    = CW'(in_byte_r[7:4]);
              ml_nxt  = ml_v;
              if (in_byte_r[1:0] == lz77td_pkg::LIT_ESC_CODE) begin
                phase_nxt = lz77td_pkg::PH_LIT_ESC;
              end else begin
                ll_v   = CW'(in_byte_r[1:0] - 2'd1);
                ll_nxt = ll_v;
                if (in_byte_r[7:4] == lz77td_pkg::LEN_ESC_CODE) begin
                  phase_nxt = lz77td_pkg::PH_LEN_ESC;
                end else begin
                  phase_nxt = after_counts(ll_v, ml_v);
                end
              end
            end
            lz77td_pkg::PH_LIT_ESC: begin
              ll_v   = CW'(in_byte_r) + lz77td_pkg::LIT_ESC_BIAS;
              ll_nxt = ll_v;
              if (ml_r == CW'(lz77td_pkg::LEN_ESC_CODE)) begin
                phase_nxt = lz77td_pkg::PH_LEN_ESC;
              end else begin
                phase_nxt = after_counts(ll_v, ml_r);
              end
            end
            lz77td_pkg::PH_LEN_ESC: begin
              ml_v      = CW'(in_byte_r) + lz77td_pkg::LEN_ESC_BIAS;
              ml_nxt    = ml_v;
              phase_nxt = after_counts(ll_r, ml_v);
            end
            lz77td_pkg::PH_LITERALS: begin
              win_wr.en     = 1'b1;
              win_wr.addr   = wp_r;
              win_wr.data   = in_byte_r;
              wp_nxt        = wp_r + 1'b1;
              prod_nxt      = (prod_r != lz77td_pkg::PROD_MAX) ? prod_r + 1'b1 : prod_r;
              out_bytes_nxt = OW'(in_byte_r);
              out_count_nxt = NW'(1);
              ll_v          = ll_r - 1'b1;
              ll_nxt        = ll_v;
              phase_nxt     = after_counts(ll_v, ml_r);
            end
            lz77td_pkg::PH_OFF_LOW: begin
              ol_nxt = in_byte_r;
              if (ohc_r == lz77td_pkg::OFF_ESC_CODE) begin
                phase_nxt = lz77td_pkg::PH_OFF_HIGH;
              end else begin
                offset   = {6'd0, ohc_r, in_byte_r};
                do_check = 1'b1;
              end
            end
            lz77td_pkg::PH_OFF_HIGH: begin
              offset   = {in_byte_r, ol_r};
              do_check = 1'b1;
            end
            default: begin
              // drain after an error: drop the byte
            end
          endcase

          // Validate the distance, then start the copy or latch the error
          if (do_check) begin
            if ((offset == '0) || (offset > prod_r)) begin
              err         = lz77td_pkg::ERR_RANGE;
              err_lat_nxt = 1'b1;
              phase_nxt   = lz77td_pkg::PH_DRAIN;
            end else begin
              load_out     = 1'b0;
              state_nxt    = lz77td_pkg::S_COPY;
              src_nxt      = wp_r - offset;
              left_nxt     = ml_r + lz77td_pkg::MATCH_BIAS;
              pend_nxt     = 1'b0;
              acc_nxt      = '0;
              lane_nxt     = '0;
              copy_end_nxt = in_end_r;
              ml_nxt       = '0;
              phase_nxt    = lz77td_pkg::PH_OPCODE;
            end
          end

          // Close the stream on its final byte
          if (load_out && in_end_r) begin
            if ((err == lz77td_pkg::ERR_NONE) && !err_lat_nxt &&
                (phase_nxt != lz77td_pkg::PH_OPCODE)) begin
              err = lz77td_pkg::ERR_TRUNC;
            end
            clear = 1'b1;
          end

          out_err_nxt  = err;
          out_last_nxt = 1'b1;
          out_done_nxt = in_end_r;
        end
      end

      lz77td_pkg::S_COPY: begin
        if (!word_done || out_free) begin
          // Write back the fetched byte and pack it
          if (pend_r) begin
            win_wr.en   = 1'b1;
            win_wr.addr = wp_r;
            win_wr.data = win_q;
            wp_nxt      = wp_r + 1'b1;
            prod_nxt    = (prod_r != lz77td_pkg::PROD_MAX) ? prod_r + 1'b1 : prod_r;
            acc_w[BW*lane_r +: BW] = win_q;
            if (word_done) begin
              load_out      = 1'b1;
              out_bytes_nxt = acc_w;
              out_count_nxt = NW'(lane_r) + NW'(1);
              out_err_nxt   = lz77td_pkg::ERR_NONE;
              out_last_nxt  = (left_r == '0);
              out_done_nxt  = copy_end_r;
              acc_nxt       = '0;
              lane_nxt      = '0;
            end else begin
              acc_nxt  = acc_w;
              lane_nxt = lane_r + 1'b1;
            end
          end

          // Issue the next window read
          if (left_r != '0) begin
            win_rd.en   = 1'b1;
            win_rd.addr = src_r;
            src_nxt     = src_r + 1'b1;
            left_nxt    = left_r - 1'b1;
            pend_nxt    = 1'b1;
          end else begin
            pend_nxt = 1'b0;
          end

          // Finish the match
          if (pend_r && (left_r == '0)) begin
            state_nxt = lz77td_pkg::S_IDLE;
            clear     = copy_end_r;
          end
        end
      end

      default: begin
        state_nxt = lz77td_pkg::S_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end

    // Return the stream state to its start values
    if (clear) begin
      phase_nxt   = lz77td_pkg::PH_OPCODE;
      ll_nxt      = '0;
      ml_nxt      = '0;
      ohc_nxt     = '0;
      ol_nxt      = '0;
      wp_nxt      = '0;
      prod_nxt    = '0;
      err_lat_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      state_r     <= lz77td_pkg::S_IDLE;
      phase_r     <= lz77td_pkg::PH_OPCODE;
      ll_r        <= '0;
      ml_r        <= '0;
      ohc_r       <= '0;
      ol_r        <= '0;
      wp_r        <= '0;
      prod_r      <= '0;
      err_lat_r   <= 1'b0;
      copy_end_r  <= 1'b0;
      left_r      <= '0;
      pend_r      <= 1'b0;
      lane_r      <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_full_r   <= in_full_nxt;
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      ll_r        <= ll_nxt;
      ml_r        <= ml_nxt;
      ohc_r       <= ohc_nxt;
      ol_r        <= ol_nxt;
      wp_r        <= wp_nxt;
      prod_r      <= prod_nxt;
      err_lat_r   <= err_lat_nxt;
      copy_end_r  <= copy_end_nxt;
      left_r      <= left_nxt;
      pend_r      <= pend_nxt;
      lane_r      <= lane_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    in_byte_r   <= in_byte_nxt;
    in_end_r    <= in_end_nxt;
    src_r       <= src_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_count_r <= out_count_nxt;
    out_err_r   <= out_err_nxt;
    out_last_r  <= out_last_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_bytes       = out_bytes_r;
  assign out_count       = out_count_r;
  assign out_error_code  = out_err_r;
  assign out_run_last    = out_last_r;
  assign out_stream_done = out_done_r;

  // ------------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------------

  // A result that is not the last of its byte is a full word
  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_run_last) |-> (out_count == NW'(OUT_LANES)))
    else $error("non-final result is not a full word");

  // Error results end their byte; a range error carries no bytes
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_error_code != lz77td_pkg::ERR_NONE)) |->
      (out_run_last &&
       ((out_error_code != lz77td_pkg::ERR_RANGE) || (out_count == '0))))
    else $error("error result carries bytes or is not final");

  // No read is in flight outside a copy
  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lz77td_pkg::S_IDLE) |-> !pend_r)
    else $error("window read pending while idle");

  // A copy that ends returns to idle with nothing left to fetch
  a_copy_end: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r == lz77td_pkg::S_COPY) && (state_r == lz77td_pkg::S_IDLE))
      |-> (left_r == '0))
    else $error("copy left with bytes outstanding");

endmodule

`default_nettype wire
